FILE: rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP matcher package
// Shared widths, constants, state machine codes and the RAM request bundle.
// ----------------------------------------------------------------------------
package kmp_pkg;

   localparam int BYTE_W     = 8;
   localparam int STATE_W    = 7;
   localparam int OFFSET_W   = 16;
   localparam int INDEX_W    = 6;
   localparam int ALPHABET   = 256;

   // longest text the offset counter tracks before it saturates
   localparam longint unsigned MAX_TEXT = 64'd65536;
   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
      (MAX_TEXT - 64'd1 > 64'd65535) ? 16'hFFFF : OFFSET_W'(MAX_TEXT - 64'd1);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TEXT = 1'b1;

   typedef logic [STATE_W-1:0]  state_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [OFFSET_W-1:0] offset_type;

   typedef enum logic [1:0] {
      LD_IDLE,
      LD_SWEEP,
      LD_LAST
   } ld_state_type;

   typedef enum logic {
      SC_IDLE,
      SC_STEP
   } sc_state_type;

   // one read and one write access to the transition table
   typedef struct packed {
      logic      rd_en;
      state_type rd_row;
      byte_type  rd_col;
      logic      wr_en;
      state_type wr_row;
      byte_type  wr_col;
      state_type wr_data;
   } ram_req_type;

endpackage

FILE: rtl/kmp_ram.sv
// ----------------------------------------------------------------------------
// KMP generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kmp_loader.sv
// ----------------------------------------------------------------------------
// KMP row builder
// Builds one transition row per pattern byte by sweeping the shadow row.
// ----------------------------------------------------------------------------
module kmp_loader #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [5:0]           pattern_index,
   input  kmp_pkg::byte_type    byte_value,
   input  kmp_pkg::state_type   rd_data,
   output kmp_pkg::ram_req_type ram_req,
   output logic                 idle
);

   import kmp_pkg::*;

   ld_state_type state_ff, state_in;
   byte_type     cnt_ff, cnt_in;
   state_type    row_ff, row_in;
   byte_type     byte_ff, byte_in;
   logic         zsrc_ff, zsrc_in;
   state_type    shadow_ff, shadow_in;
   state_type    cap_ff, cap_in;
   logic         wv_ff;
   byte_type     wcol_ff;
   state_type    src;
   logic         idx_ok;
   logic         shadow_ok;

   assign idx_ok    = {3'b000, pattern_index} < 9'(MAX_PATTERN);
   assign shadow_ok = {2'b00, shadow_ff} < 9'(MAX_PATTERN);
   // rows beyond the table and row zero read as zeros
   assign src       = zsrc_ff ? '0 : rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LD_IDLE;
         shadow_ff <= '0;
         wv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         shadow_ff <= shadow_in;
         wv_ff     <= (state_ff == LD_SWEEP);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      row_ff  <= row_in;
      byte_ff <= byte_in;
      zsrc_ff <= zsrc_in;
      cap_ff  <= cap_in;
      wcol_ff <= cnt_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      byte_in   = byte_ff;
      zsrc_in   = zsrc_ff;
      shadow_in = shadow_ff;
      cap_in    = cap_ff;
      ram_req   = '0;
      idle      = 1'b0;

      // write stage runs in the cycle after its read
      if (wv_ff) begin
         ram_req.wr_en  = 1'b1;
         ram_req.wr_row = row_ff;
         ram_req.wr_col = wcol_ff;
         if (wcol_ff == byte_ff) begin
            ram_req.wr_data = row_ff + 7'd1;
            cap_in          = src;
         end else begin
            ram_req.wr_data = src;
         end
      end

      unique case (state_ff)
         LD_IDLE: begin
            idle = 1'b1;
            if (start && idx_ok) begin
               row_in   = STATE_W'(pattern_index);
               byte_in  = byte_value;
               zsrc_in  = (pattern_index == '0) || !shadow_ok;
               cnt_in   = '0;
               state_in = LD_SWEEP;
            end
         end
         LD_SWEEP: begin
            ram_req.rd_en  = !zsrc_ff;
            ram_req.rd_row = shadow_ff;
            ram_req.rd_col = cnt_ff;
            cnt_in         = cnt_ff + 8'd1;
            if (cnt_ff == 8'hFF) begin
               state_in = LD_LAST;
            end
         end
         LD_LAST: begin
            // advance the shadow state on the pattern byte
            if (row_ff == '0) begin
               shadow_in = '0;
            end else if (shadow_ff == row_ff) begin
               shadow_in = row_ff + 7'd1;
            end else begin
               shadow_in = cap_in;
            end
            state_in = LD_IDLE;
         end
         default: state_in = LD_IDLE;
      endcase
   end

endmodule

FILE: rtl/kmp_scanner.sv
// ----------------------------------------------------------------------------
// KMP text scanner
// Steps the automaton on text bytes and holds the result register.
// ----------------------------------------------------------------------------
module kmp_scanner #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  kmp_pkg::byte_type    byte_value,
   input  logic                 end_of_text,
   input  kmp_pkg::state_type   pattern_length,
   input  kmp_pkg::state_type   rd_data,
   output kmp_pkg::ram_req_type ram_req,
   output logic                 idle,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output kmp_pkg::offset_type  rsp_offset
);

   import kmp_pkg::*;

   sc_state_type ss_ff, ss_in;
   state_type    mstate_ff, mstate_in;
   offset_type   offset_ff, offset_in;
   logic         matched_ff, matched_in;
   logic         eot_ff, eot_in;
   logic         zsrc_ff, zsrc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         found_ff, found_in;
   offset_type   roff_ff, roff_in;
   state_type    nxt;
   logic         hit;
   logic         emit;
   logic         state_ok;
   logic [16:0]  sum;
   offset_type   start_off;

   assign state_ok = {2'b00, mstate_ff} < 9'(MAX_PATTERN);
   assign nxt      = zsrc_ff ? '0 : rd_data;
   assign hit      = (pattern_length != '0) && (nxt == pattern_length);
   assign emit     = hit || eot_ff;
   assign sum      = {1'b0, offset_ff} + 17'd1;
   assign start_off = (sum >= {10'b0, pattern_length})
                      ? OFFSET_W'(sum - {10'b0, pattern_length}) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_ff        <= SC_IDLE;
         mstate_ff    <= '0;
         offset_ff    <= '0;
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ss_ff        <= ss_in;
         mstate_ff    <= mstate_in;
         offset_ff    <= offset_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eot_ff   <= eot_in;
      zsrc_ff  <= zsrc_in;
      found_ff <= found_in;
      roff_ff  <= roff_in;
   end

   always_comb begin
      ss_in        = ss_ff;
      mstate_in    = mstate_ff;
      offset_in    = offset_ff;
      matched_in   = matched_ff;
      eot_in       = eot_ff;
      zsrc_in      = zsrc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      roff_in      = roff_ff;
      ram_req      = '0;
      idle         = 1'b0;

      unique case (ss_ff)
         SC_IDLE: begin
            idle = 1'b1;
            if (start) begin
               if (matched_ff) begin
                  // drop the rest of a matched text
                  if (end_of_text) begin
                     mstate_in  = '0;
                     offset_in  = '0;
                     matched_in = 1'b0;
                  end
               end else begin
                  ram_req.rd_en  = state_ok;
                  ram_req.rd_row = mstate_ff;
                  ram_req.rd_col = byte_value;
                  eot_in         = end_of_text;
                  zsrc_in        = !state_ok;
                  ss_in          = SC_STEP;
               end
            end
         end
         SC_STEP: begin
            // hold while the result register is still occupied and a new result is due
            if (!(emit && rsp_valid_ff && !rsp_ready)) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  found_in     = hit;
                  roff_in      = hit ? start_off : '0;
               end
               if (eot_ff) begin
                  mstate_in  = '0;
                  offset_in  = '0;
                  matched_in = 1'b0;
               end else begin
                  mstate_in  = nxt;
                  matched_in = hit;
                  if (offset_ff < OFFSET_LIMIT) begin
                     offset_in = offset_ff + 16'd1;
                  end
               end
               ss_in = SC_IDLE;
            end
         end
         default: ss_in = SC_IDLE;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = found_ff;
   assign rsp_offset = roff_ff;

endmodule

FILE: rtl/kmp_automaton_byte_matcher.sv
// Pattern load: once an in-range request is taken, no request is taken until its row
//   is built (a 256-entry row sweep through the table's single read and write ports).
// Text byte: read from the table in SC_IDLE, stepped in SC_STEP; none is taken until
//   the step ends. Bytes after a match drop in SC_IDLE; the result loads in SC_STEP.
// A held result stalls the next text byte that has a result. Synchronous reset clears
//   the automaton, offset and result valid, sets length 1; the table is not cleared.
// ----------------------------------------------------------------------------
// KMP automaton byte matcher
// Substring search over a byte stream with a table-driven KMP automaton.
// ----------------------------------------------------------------------------
module kmp_automaton_byte_matcher #(
   parameter int MAX_PATTERN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // pattern_index[5:0], byte_value[13:6], zero[15:14]
   input  logic        req_tuser,  // mode
   input  logic        req_tlast,  // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // match_offset[15:0]
   output logic        rsp_tuser,  // found
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data // pattern_length
);

   import kmp_pkg::*;

   localparam int RW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int DEPTH  = MAX_PATTERN * ALPHABET;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type   plen_ff;
   ram_req_type ld_req;
   ram_req_type sc_req;
   logic        ld_idle;
   logic        sc_idle;
   logic        accept;
   state_type   rd_data;
   logic        rd_en;
   state_type   rd_row;
   byte_type    rd_col;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= 7'd1;
      end else if (csr_wr_en) begin
         plen_ff <= csr_wr_data;
      end
   end

   assign req_tready = ld_idle && sc_idle;
   assign accept     = req_tvalid && req_tready;

   kmp_loader #(.MAX_PATTERN(MAX_PATTERN)) u_loader (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && (req_tuser == MODE_LOAD)),
      .pattern_index (req_tdata[5:0]),
      .byte_value    (req_tdata[13:6]),
      .rd_data       (rd_data),
      .ram_req       (ld_req),
      .idle          (ld_idle)
   );

   kmp_scanner #(.MAX_PATTERN(MAX_PATTERN)) u_scanner (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && (req_tuser == MODE_TEXT)),
      .byte_value     (req_tdata[13:6]),
      .end_of_text    (req_tlast),
      .pattern_length (plen_ff),
      .rd_data        (rd_data),
      .ram_req        (sc_req),
      .idle           (sc_idle),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_found      (rsp_tuser),
      .rsp_offset     (rsp_tdata)
   );

   // the loader and scanner never run together; the loader owns the write port
   assign rd_en   = ld_req.rd_en || sc_req.rd_en;
   assign rd_row  = ld_req.rd_en ? ld_req.rd_row : sc_req.rd_row;
   assign rd_col  = ld_req.rd_en ? ld_req.rd_col : sc_req.rd_col;
   assign rd_addr = ADDR_W'({RW'(rd_row), rd_col});
   assign wr_addr = ADDR_W'({RW'(ld_req.wr_row), ld_req.wr_col});

   kmp_ram #(.WIDTH(STATE_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ld_req.wr_en),
      .wr_addr (wr_addr),
      .wr_data (ld_req.wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: rtl/kmp_checker.sv
// ----------------------------------------------------------------------------
// KMP port checker
// Port-level temporal checks on the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module kmp_checker #(
   parameter int MAX_PATTERN = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_wr_en,
   input logic [6:0]  csr_wr_data
);

   import kmp_pkg::*;

   logic load_taken;

   assign load_taken = req_tvalid && req_tready && (req_tuser == MODE_LOAD)
                       && ({3'b000, req_tdata[5:0]} < 9'(MAX_PATTERN));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("not-found result carries a non-zero offset");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load_taken |=> !req_tready ##1 !req_tready)
      else $error("request taken during a row build");

endmodule

bind kmp_automaton_byte_matcher kmp_checker #(.MAX_PATTERN(MAX_PATTERN)) u_kmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .req_tuser   (req_tuser),
   .req_tlast   (req_tlast),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
